### sv/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg: shared types and constants of the boost charge supervisor
// widths, fixed-point constants, command codes, register indexes, fsm states
// ----------------------------------------------------------------------------
`default_nettype none

package bcs_pkg;

    localparam int CMD_W      = 3;
    localparam int COUNT_W    = 12;
    localparam int TARGET_W   = 7;
    localparam int DUTY_W     = 20;
    localparam int SCALE_W    = 16;
    localparam int PHASE_W    = 3;
    localparam int PULSE_W    = 5;
    localparam int VOLT_W     = 20;
    localparam int ERR_W      = 22;
    localparam int STALL_W    = 8;
    localparam int LEVEL_W    = 11;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 48;
    localparam int PERIOD_W   = 16;
    localparam int MIN_W      = 12;
    localparam int MAG_W      = 16;
    localparam int RAISE_W    = 9;
    localparam int QUOT_W     = 15;
    localparam int CUT_W      = 21;
    localparam int SUM_W      = 23;

    // register reset values
    localparam logic [TARGET_W-1:0] TARGET_RST = 7'd60;
    localparam logic [DUTY_W-1:0]   LIMIT_RST  = 20'd576717;
    localparam logic [SCALE_W-1:0]  SCALE_RST  = 16'd2165;
    localparam logic [PHASE_W-1:0]  PHASE_RST  = 3'd1;
    localparam logic [PULSE_W-1:0]  PULSE_RST  = 5'd3;

    // fixed-point constants (volts in q8, duty in q20)
    localparam logic [DUTY_W-1:0]   STALL_DUTY_Q20 = 20'd314572;
    localparam logic [VOLT_W-1:0]   STALL_VOLTS_Q8 = 20'd6656;
    localparam logic [7:0]          CLAMP_MARGIN_V = 8'd12;
    localparam logic [7:0]          CLAMP_MAX_V    = 8'd95;
    localparam logic signed [ERR_W-1:0] DEADBAND_Q8 = 22'sd128;
    localparam logic [MIN_W-1:0]    FULL_ERR_Q8    = 12'd2560;
    localparam logic [MAG_W-1:0]    CUT_ERR_SAT    = 16'hFFFF;
    // 315/2560 reduces to 63/512
    localparam logic [5:0]          RAISE_MUL      = 6'd63;
    localparam int                  RAISE_SHIFT    = 9;
    // floor(12*b/25) estimate: 12*ceil(2^18/25), off by at most one
    localparam logic [16:0]         CUT_RECIP      = 17'd125832;
    localparam int                  CUT_SHIFT      = 18;
    localparam logic [SUM_W-1:0]    CUT_BASE_Q20   = 23'd3932;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE      = 3'd0,
        CMD_CHARGE    = 3'd1,
        CMD_BOOST_OFF = 3'd2,
        CMD_KILL      = 3'd3,
        CMD_DROP      = 3'd4,
        CMD_AUTO      = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_LIMIT  = 3'd1,
        REG_SCALE  = 3'd2,
        REG_PHASE  = 3'd3,
        REG_PULSE  = 3'd4
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_STEP,
        ST_UPDATE,
        ST_PUBLISH
    } t_state;

    typedef enum logic [1:0] {
        ADJ_NONE,
        ADJ_RAISE,
        ADJ_CUT
    } t_adj;

    typedef struct packed {
        logic load;
        logic eval;
        logic step;
        logic update;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [DUTY_W-1:0]   duty_limit;
        logic [SCALE_W-1:0]  bus_scale;
        logic [PHASE_W-1:0]  phase_en;
        logic [PULSE_W-1:0]  pulse_ms;
    } t_cfg;

    // packed msb first, so level_phase_one lands in the lowest bits
    typedef struct packed {
        logic [1:0]         pad;
        logic               ready_light;
        logic               stall_trip;
        logic               clamp_trip;
        logic               drop_refused;
        logic [PULSE_W-1:0] drop_length_ms;
        logic               drop_fire;
        logic               auto_out;
        logic               charging_out;
        logic               kill_out;
        logic [LEVEL_W-1:0] level_phase_three;
        logic [LEVEL_W-1:0] level_phase_two;
        logic [LEVEL_W-1:0] level_phase_one;
    } t_result;

endpackage

`default_nettype wire

### sv/bcs_regs.sv
// ----------------------------------------------------------------------------
// bcs_regs: configuration register file
// apb-style write and read of the five supervisor settings
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_regs import bcs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [TARGET_W-1:0] r_target;
    logic [DUTY_W-1:0]   r_limit;
    logic [SCALE_W-1:0]  r_scale;
    logic [PHASE_W-1:0]  r_phase;
    logic [PULSE_W-1:0]  r_pulse;
    logic                w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST;
            r_limit  <= LIMIT_RST;
            r_scale  <= SCALE_RST;
            r_phase  <= PHASE_RST;
            r_pulse  <= PULSE_RST;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_TARGET: r_target <= pwdata[TARGET_W-1:0];
                REG_LIMIT:  r_limit  <= pwdata[DUTY_W-1:0];
                REG_SCALE:  r_scale  <= pwdata[SCALE_W-1:0];
                REG_PHASE:  r_phase  <= pwdata[PHASE_W-1:0];
                REG_PULSE:  r_pulse  <= pwdata[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_TARGET: prdata = DATA_W'(r_target);
            REG_LIMIT:  prdata = DATA_W'(r_limit);
            REG_SCALE:  prdata = DATA_W'(r_scale);
            REG_PHASE:  prdata = DATA_W'(r_phase);
            REG_PULSE:  prdata = DATA_W'(r_pulse);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.target     = r_target;
    assign o_cfg.duty_limit = r_limit;
    assign o_cfg.bus_scale  = r_scale;
    assign o_cfg.phase_en   = r_phase;
    assign o_cfg.pulse_ms   = r_pulse;

endmodule

`default_nettype wire

### sv/bcs_ctrl.sv
// ----------------------------------------------------------------------------
// bcs_ctrl: tick sequencer
// walks one item through evaluate, step, duty update and publish
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_ctrl import bcs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  t_dp_sts   i_sts,
    output t_dp_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_EVAL;
            ST_EVAL:    n_state = ST_STEP;
            ST_STEP:    n_state = ST_UPDATE;
            ST_UPDATE:  n_state = ST_PUBLISH;
            ST_PUBLISH: if (!i_sts.out_busy) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_EVAL:    o_cmd.eval    = 1'b1;
            ST_STEP:    o_cmd.step    = 1'b1;
            ST_UPDATE:  o_cmd.update  = 1'b1;
            ST_PUBLISH: o_cmd.publish = !i_sts.out_busy;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_load_starts_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_EVAL))
        else $error("accepted item did not start evaluation");
`endif

endmodule

`default_nettype wire

### sv/bcs_dp.sv
// ----------------------------------------------------------------------------
// bcs_dp: supervisor datapath
// bus scaling, trips, command decode, duty step and pwm levels
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_dp import bcs_pkg::*; #(
    parameter int unsigned PWM_PERIOD  = 1499,
    parameter int unsigned STALL_LIMIT = 200
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  t_cfg                    i_cfg,
    input  wire logic [CMD_W-1:0]   i_command,
    input  wire logic [COUNT_W-1:0] i_bus_count,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output t_result                 o_result
);

    // supervisor state
    logic [DUTY_W-1:0]  r_duty;
    logic [DUTY_W-1:0]  n_duty;
    logic               r_charge;
    logic               r_auto;
    logic               r_kill;
    logic [STALL_W-1:0] r_stall;

    // item and pipeline registers
    logic [CMD_W-1:0]   r_cmd;
    logic [VOLT_W-1:0]  r_v;
    t_adj               r_adj;
    logic [MIN_W-1:0]   r_m;
    logic [MAG_W-1:0]   r_b;
    logic [RAISE_W-1:0] r_raise;
    logic [QUOT_W-1:0]  r_q0;
    logic               r_fire;
    logic               r_refused;
    logic               r_ctrip;
    logic               r_strip;
    logic               r_ready;
    logic               r_out_valid;
    t_result            r_result;

    // scale
    logic [COUNT_W+SCALE_W-1:0] w_v_prod;

    // evaluation
    logic [7:0]              w_clamp_sum;
    logic [TARGET_W-1:0]     w_clamp_v;
    logic                    w_over;
    logic                    w_v_low;
    logic [24:0]             w_v25;
    logic [24:0]             w_t25;
    logic                    w_drop_low;
    logic                    w_auto_hi;
    logic                    w_ready_hi;
    logic signed [ERR_W-1:0] w_err;
    logic [ERR_W-1:0]        w_err_mag;
    logic                    ev_charge;
    logic                    ev_auto;
    logic                    ev_kill;
    logic [DUTY_W-1:0]       ev_duty;
    logic [STALL_W-1:0]      ev_stall;
    logic                    ev_fire;
    logic                    ev_refused;
    logic                    ev_ctrip;
    logic                    ev_strip;
    t_adj                    ev_adj;
    logic [MIN_W-1:0]        ev_m;
    logic [MAG_W-1:0]        ev_b;

    // step and update
    logic [MIN_W+5:0]          w_raise_prod;
    logic [MAG_W+16:0]         w_q0_prod;
    logic [VOLT_W-1:0]         w_c;
    logic [VOLT_W-1:0]         w_chk;
    logic [QUOT_W-1:0]         w_q;
    logic [CUT_W-1:0]          w_cut;
    logic signed [SUM_W-1:0]   w_sum;
    logic [DUTY_W-1:0]         w_upd_duty;

    // levels
    logic [DUTY_W+PERIOD_W-1:0] w_lvl_prod;
    logic [LEVEL_W-1:0]         w_lvl;

    assign w_v_prod = i_bus_count * i_cfg.bus_scale;

    // clamp at min(target + 12, 95) volts
    assign w_clamp_sum = {1'b0, i_cfg.target} + CLAMP_MARGIN_V;
    assign w_clamp_v   = (w_clamp_sum > CLAMP_MAX_V) ? CLAMP_MAX_V[TARGET_W-1:0]
                                                     : w_clamp_sum[TARGET_W-1:0];
    assign w_over      = r_v > {5'b0, w_clamp_v, 8'b0};
    assign w_v_low     = r_v < STALL_VOLTS_Q8;

    // ratio tests against the target as exact cross products
    assign w_v25      = 25'(r_v);
    assign w_t25      = 25'(i_cfg.target);
    assign w_drop_low = (w_v25 * 25'd5) < (w_t25 * 25'd1024);
    assign w_auto_hi  = (w_v25 * 25'd20) >= (w_t25 * 25'd4864);
    assign w_ready_hi = (w_v25 * 25'd10) >= (w_t25 * 25'd2304);

    assign w_err     = $signed({7'b0, i_cfg.target, 8'b0}) - $signed({2'b0, r_v});
    assign w_err_mag = ERR_W'(-w_err);

    always_comb begin
        ev_charge  = r_charge;
        ev_auto    = r_auto;
        ev_kill    = r_kill;
        ev_duty    = r_duty;
        ev_stall   = '0;
        ev_fire    = 1'b0;
        ev_refused = 1'b0;
        ev_ctrip   = 1'b0;
        ev_strip   = 1'b0;
        ev_adj     = ADJ_NONE;
        ev_m       = '0;
        ev_b       = '0;

        // overvoltage clamp
        if (w_over) begin
            ev_ctrip  = 1'b1;
            ev_charge = 1'b0;
            ev_auto   = 1'b0;
            ev_duty   = '0;
            ev_kill   = 1'b1;
        end

        // stall watchdog, trips on the tick after the limit is reached
        if (ev_charge && (ev_duty > STALL_DUTY_Q20) && w_v_low) begin
            if (r_stall >= STALL_W'(STALL_LIMIT)) begin
                ev_strip  = 1'b1;
                ev_charge = 1'b0;
                ev_auto   = 1'b0;
                ev_duty   = '0;
                ev_kill   = 1'b1;
            end else begin
                ev_stall = r_stall + 1'b1;
            end
        end

        unique case (r_cmd)
            CMD_CHARGE: begin
                ev_charge = 1'b1;
                ev_duty   = '0;
                ev_kill   = 1'b0;
            end
            CMD_BOOST_OFF: begin
                ev_charge = 1'b0;
                ev_duty   = '0;
            end
            CMD_KILL: begin
                ev_charge = 1'b0;
                ev_auto   = 1'b0;
                ev_duty   = '0;
                ev_kill   = 1'b1;
            end
            CMD_DROP: begin
                if (w_drop_low) begin
                    ev_refused = 1'b1;
                end else begin
                    ev_fire = 1'b1;
                end
            end
            CMD_AUTO: begin
                ev_auto = !ev_auto;
                if (ev_auto) begin
                    ev_charge = 1'b1;
                    ev_kill   = 1'b0;
                end
            end
            default: ;
        endcase

        // deadband decision, the step itself follows in the step and update states
        if (ev_charge) begin
            if (w_err > DEADBAND_Q8) begin
                ev_adj = ADJ_RAISE;
                ev_m   = (w_err > $signed({10'b0, FULL_ERR_Q8})) ? FULL_ERR_Q8
                                                                 : w_err[MIN_W-1:0];
            end else if (w_err < -DEADBAND_Q8) begin
                ev_adj = ADJ_CUT;
                // beyond the saturation the cut drives duty to zero anyway
                ev_b   = (w_err_mag > {6'b0, CUT_ERR_SAT}) ? CUT_ERR_SAT
                                                           : w_err_mag[MAG_W-1:0];
            end
        end

        if (ev_auto && w_auto_hi) begin
            ev_fire = 1'b1;
        end
    end

    // raise = m*63/512, cut quotient estimate of 12*b/25
    assign w_raise_prod = r_m * RAISE_MUL;
    assign w_q0_prod    = r_b * CUT_RECIP;

    // correct the estimate, then cut = 20*b + floor(12*b/25) = floor(512*b/25)
    assign w_c   = VOLT_W'(r_b) * VOLT_W'(12);
    assign w_chk = VOLT_W'(r_q0) * VOLT_W'(25);
    assign w_q   = (w_chk > w_c) ? r_q0 - 1'b1 : r_q0;
    assign w_cut = CUT_W'(r_b) * CUT_W'(20) + CUT_W'(w_q);

    always_comb begin
        if (r_adj == ADJ_RAISE) begin
            w_sum = $signed({3'b0, r_duty}) + $signed({14'b0, r_raise});
        end else begin
            w_sum = $signed({3'b0, r_duty}) - $signed(CUT_BASE_Q20)
                  - $signed({2'b0, w_cut});
        end
        if (w_sum < 0) begin
            w_upd_duty = '0;
        end else if (w_sum > $signed({3'b0, i_cfg.duty_limit})) begin
            w_upd_duty = i_cfg.duty_limit;
        end else begin
            w_upd_duty = w_sum[DUTY_W-1:0];
        end
    end

    always_comb begin
        n_duty = r_duty;
        if (i_cmd.eval) begin
            n_duty = ev_duty;
        end else if (i_cmd.update && (r_adj != ADJ_NONE)) begin
            n_duty = w_upd_duty;
        end
    end

    assign w_lvl_prod = r_duty * PERIOD_W'(PWM_PERIOD);
    assign w_lvl      = w_lvl_prod[DUTY_W+LEVEL_W-1:DUTY_W];

    // control and supervisor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty      <= '0;
            r_charge    <= 1'b0;
            r_auto      <= 1'b0;
            r_kill      <= 1'b1;
            r_stall     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_duty <= n_duty;
            if (i_cmd.eval) begin
                r_charge <= ev_charge;
                r_auto   <= ev_auto;
                r_kill   <= ev_kill;
                r_stall  <= ev_stall;
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_v   <= w_v_prod[COUNT_W+SCALE_W-1:8];
        end
        if (i_cmd.eval) begin
            r_adj     <= ev_adj;
            r_m       <= ev_m;
            r_b       <= ev_b;
            r_fire    <= ev_fire;
            r_refused <= ev_refused;
            r_ctrip   <= ev_ctrip;
            r_strip   <= ev_strip;
            r_ready   <= w_ready_hi;
        end
        if (i_cmd.step) begin
            r_raise <= w_raise_prod[MIN_W+5:RAISE_SHIFT];
            r_q0    <= w_q0_prod[CUT_SHIFT+QUOT_W-1:CUT_SHIFT];
        end
        if (i_cmd.publish) begin
            r_result.pad               <= '0;
            r_result.level_phase_one   <= i_cfg.phase_en[0] ? w_lvl : '0;
            r_result.level_phase_two   <= i_cfg.phase_en[1] ? w_lvl : '0;
            r_result.level_phase_three <= i_cfg.phase_en[2] ? w_lvl : '0;
            r_result.kill_out          <= r_kill;
            r_result.charging_out      <= r_charge;
            r_result.auto_out          <= r_auto;
            r_result.drop_fire         <= r_fire;
            r_result.drop_length_ms    <= r_fire ? i_cfg.pulse_ms : '0;
            r_result.drop_refused      <= r_refused;
            r_result.clamp_trip        <= r_ctrip;
            r_result.stall_trip        <= r_strip;
            r_result.ready_light       <= r_ready;
        end
    end

    assign o_sts.out_busy = r_out_valid & ~i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_result       = r_result;

`ifndef SYNTHESIS
    a_stall_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stall <= STALL_W'(STALL_LIMIT))
        else $error("stall count beyond its limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> !o_sts.out_busy)
        else $error("result published over a waiting item");

    a_duty_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.eval || i_cmd.update) |=> $stable(r_duty))
        else $error("duty moved outside its update steps");

    a_kill_excludes_charge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_kill && r_charge))
        else $error("charge loop active while gates are killed");
`endif

endmodule

`default_nettype wire

### sv/boost_charge_supervisor_core.sv
// ----------------------------------------------------------------------------
// boost_charge_supervisor_core: charge supervisor for a boost converter
// one item per 10 ms tick: bus adc count and command in, pwm levels and flags out
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one tick item: tdata = {pad, bus_count, command}. m_axis
//   returns exactly one result item per tick with the three phase pwm levels,
//   the kill, charge and auto flags, the drop pulse and the trip indications.
//   the apb port sets target, duty limit, bus scale, phase enables and pulse
//   length; write it only while no tick is in flight.
// timing
//   an accepted item shows on m_axis after the evaluate, step, update and
//   publish states; the next item is taken only after publish. scale
//   multiply at accept, then evaluate, quotient multiply, duty update and
//   level multiply each take one step, so the duty of one tick feeds the next.
// reset
//   synchronous, active low: registers return to their defaults, duty and
//   stall count clear, charge and auto drop, kill is set, m_axis goes idle.
// back-pressure
//   the result waits in the output register while m_axis_tready is low. the
//   next item is still accepted and runs until its publish step, where the
//   sequencer holds until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module boost_charge_supervisor_core import bcs_pkg::*; #(
    parameter int unsigned PWM_PERIOD  = 1499,
    parameter int unsigned STALL_LIMIT = 200
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    output logic      [DATA_W-1:0]      prdata,
    output logic                        pready,
    // tick items in
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [2:0] command, [14:3] bus_count, [15] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result items out
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [10:0] level_phase_one, [21:11] level_phase_two, [32:22] level_phase_three,
    // [33] kill_out, [34] charging_out, [35] auto_out, [36] drop_fire,
    // [41:37] drop_length_ms, [42] drop_refused, [43] clamp_trip,
    // [44] stall_trip, [45] ready_light, [47:46] zero
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_result w_result;

    // register file
    bcs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer: accept only in idle, hold publish while the output is stalled
    bcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath with supervisor state and output register
    bcs_dp #(
        .PWM_PERIOD  (PWM_PERIOD),
        .STALL_LIMIT (STALL_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg       (w_cfg),
        .i_command   (s_axis_tdata[CMD_W-1:0]),
        .i_bus_count (s_axis_tdata[CMD_W+COUNT_W-1:CMD_W]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (w_result)
    );

    // result struct is laid out to match the tdata packing
    assign m_axis_tdata = w_result;

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for boost_charge_supervisor_core
// drives tick items on s_axis and register writes on apb, predicts every result
// item in a local model of the supervisor and compares it field by field on
// m_axis; a directed table comes first, then long charge ramps and random
// ticks under several register settings, with random stalls on both sides
// ----------------------------------------------------------------------------
module testbench;
    import bcs_pkg::*;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // supervisor constants, volts in q8 and duty in q20
    localparam int PWM_LEVEL_PERIOD = 1499;
    localparam int STALL_TICKS_MAX  = 200;
    localparam int CLAMP_MARGIN     = 12;
    localparam int CLAMP_CEIL       = 95;
    localparam int STALL_DUTY_MIN   = 314572;
    localparam int LOW_BUS_Q8       = 26 * 256;
    localparam int DEADBAND         = 128;
    localparam int ERR_FULL         = 2560;
    localparam int RAISE_STEP       = 315;
    localparam int CUT_STEP         = 3932;

    // run shape
    localparam int DIRECTED_ROWS   = 23;
    localparam int RAMP_TICKS      = 30;
    localparam int STALL_RUN_TICKS = 1215;
    localparam int RANDOM_SETS     = 7;
    localparam int RANDOM_TICKS    = 45;
    localparam int PRESSURE_AT     = 300;
    localparam int PRESSURE_HOLD   = 120;
    localparam int DRAIN_CYCLES    = 8;
    localparam int TAIL_CYCLES     = 20;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [COUNT_W-1:0] cnt;
        bit                 known;
        t_result            want;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [ADDR_W-1:0]      paddr         = '0;
    logic [DATA_W-1:0]      pwdata        = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [2:0] command, [14:3] bus_count, [15] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [10:0] level_phase_one, [21:11] level_phase_two, [32:22] level_phase_three,
    // [33] kill_out, [34] charging_out, [35] auto_out, [36] drop_fire,
    // [41:37] drop_length_ms, [42] drop_refused, [43] clamp_trip,
    // [44] stall_trip, [45] ready_light, [47:46] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // local copy of the registers
    logic [TARGET_W-1:0] cfg_target;
    logic [DUTY_W-1:0]   cfg_limit;
    logic [SCALE_W-1:0]  cfg_scale;
    logic [PHASE_W-1:0]  cfg_phase;
    logic [PULSE_W-1:0]  cfg_pulse;

    // local copy of the supervisor state
    logic [DUTY_W-1:0]   duty_q20;
    logic                charging;
    logic                auto_mode;
    logic                killed;
    logic [STALL_W-1:0]  stall_ticks;

    // results still owed by the block, oldest first
    t_result pending_results[$];

    int error_count    = 0;
    int ticks_sent     = 0;
    int results_seen   = 0;
    int settings_used  = 0;
    int clamp_trips    = 0;
    int stall_trips    = 0;
    int drops_fired    = 0;
    int drops_refused  = 0;

    boost_charge_supervisor_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // gap length: mostly none, some short, a few long
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DUTY_W-1:0] clip_duty(input longint d);
        longint lim;
        lim = cfg_limit;
        if (d < 0) return '0;
        if (d > lim) return cfg_limit;
        return d[DUTY_W-1:0];
    endfunction

    // everything off, gates killed
    function automatic void shut_down();
        charging  = 1'b0;
        auto_mode = 1'b0;
        duty_q20  = '0;
        killed    = 1'b1;
    endfunction

    // one 10 ms tick of the supervisor: advances the local state, returns the result
    function automatic t_result predict_tick(input logic [CMD_W-1:0] cmd,
                                             input logic [COUNT_W-1:0] cnt);
        longint  volts, tgt, tgt_q8, clamp_v, err, mag, duty_l, lvl;
        logic    fire;
        t_result r;
        r     = '0;
        fire  = 1'b0;
        volts = cnt;
        volts = (volts * cfg_scale) >> 8;
        tgt   = cfg_target;
        tgt_q8 = tgt * 256;

        // overvoltage clamp at min(target + 12, 95) volts
        clamp_v = tgt + CLAMP_MARGIN;
        if (clamp_v > CLAMP_CEIL) clamp_v = CLAMP_CEIL;
        if (volts > clamp_v * 256) begin
            shut_down();
            r.clamp_trip = 1'b1;
        end

        // stall watchdog: high duty but the bus does not come up
        if (charging && duty_q20 > STALL_DUTY_MIN && volts < LOW_BUS_Q8) begin
            stall_ticks = stall_ticks + 1'b1;
            if (stall_ticks > STALL_TICKS_MAX) begin
                shut_down();
                stall_ticks  = '0;
                r.stall_trip = 1'b1;
            end
        end else begin
            stall_ticks = '0;
        end

        case (cmd)
            CMD_CHARGE: begin
                charging = 1'b1;
                duty_q20 = '0;
                killed   = 1'b0;
            end
            CMD_BOOST_OFF: begin
                charging = 1'b0;
                duty_q20 = clip_duty(0);
            end
            CMD_KILL: shut_down();
            CMD_DROP: begin
                // refused below 0.8 of target
                if (5 * volts < tgt * 1024) r.drop_refused = 1'b1;
                else fire = 1'b1;
            end
            CMD_AUTO: begin
                auto_mode = !auto_mode;
                if (auto_mode) begin
                    charging = 1'b1;
                    killed   = 1'b0;
                end
            end
            default: ;
        endcase

        // proportional step with a half-volt deadband
        if (charging) begin
            err    = tgt_q8 - volts;
            duty_l = duty_q20;
            if (err > DEADBAND) begin
                mag = (err > ERR_FULL) ? ERR_FULL : err;
                duty_q20 = clip_duty(duty_l + (RAISE_STEP * mag) / ERR_FULL);
            end else if (err < -DEADBAND) begin
                duty_q20 = clip_duty(duty_l - CUT_STEP + (err * 512) / 25);
            end
        end

        // auto fire at 0.95 of target, merges with a single drop
        if (auto_mode && volts * 20 >= tgt * 4864) fire = 1'b1;

        duty_l = duty_q20;
        lvl    = (duty_l * PWM_LEVEL_PERIOD) >> 20;
        r.level_phase_one   = cfg_phase[0] ? lvl[LEVEL_W-1:0] : '0;
        r.level_phase_two   = cfg_phase[1] ? lvl[LEVEL_W-1:0] : '0;
        r.level_phase_three = cfg_phase[2] ? lvl[LEVEL_W-1:0] : '0;
        r.kill_out          = killed;
        r.charging_out      = charging;
        r.auto_out          = auto_mode;
        r.drop_fire         = fire;
        r.drop_length_ms    = fire ? cfg_pulse : '0;
        r.ready_light       = (volts * 10 >= tgt * 2304);
        return r;
    endfunction

    // hand-written result for the directed rows: flags only, levels at zero
    function automatic t_result flag_result(input bit kill, input bit charge,
                                            input bit refused, input bit clamp,
                                            input bit ready, input int pulse);
        t_result r;
        r                = '0;
        r.kill_out       = kill;
        r.charging_out   = charge;
        r.drop_refused   = refused;
        r.clamp_trip     = clamp;
        r.ready_light    = ready;
        r.drop_fire      = (pulse != 0);
        r.drop_length_ms = pulse[PULSE_W-1:0];
        return r;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // apb write: setup cycle, access cycle, register taken at the pready edge
    task automatic apb_write(input t_reg idx, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TARGET: cfg_target = value[TARGET_W-1:0];
            REG_LIMIT:  cfg_limit  = value[DUTY_W-1:0];
            REG_SCALE:  cfg_scale  = value[SCALE_W-1:0];
            REG_PHASE:  cfg_phase  = value[PHASE_W-1:0];
            REG_PULSE:  cfg_pulse  = value[PULSE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input int target, input int limit, input int scale,
                                 input int phase, input int pulse);
        apb_write(REG_TARGET, target);
        apb_write(REG_LIMIT, limit);
        apb_write(REG_SCALE, scale);
        apb_write(REG_PHASE, phase);
        apb_write(REG_PULSE, pulse);
        settings_used++;
    endtask

    // offer one tick item; tvalid stays high when the next item follows at once
    task automatic send_tick(input logic [CMD_W-1:0] cmd, input logic [COUNT_W-1:0] cnt,
                             input bit known = 1'b0, input t_result want = '0);
        int      gap;
        t_result r;
        gap = idle_span();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, cnt, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_tick(cmd, cnt);
        clamp_trips   += r.clamp_trip;
        stall_trips   += r.stall_trip;
        drops_fired   += r.drop_fire;
        drops_refused += r.drop_refused;
        pending_results.push_back(known ? want : r);
        ticks_sent++;
    endtask

    // stop offering and wait until every owed result has come out
    task automatic drain_ticks();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stalls, steady stretches, one long hold-off
    initial begin : result_sink
        int  span;
        bit  pressure_done;
        pressure_done = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!pressure_done && results_seen >= PRESSURE_AT) begin
                // long hold so the block fills up and stalls s_axis
                pressure_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (PRESSURE_HOLD) @(posedge i_clk);
            end else if ($urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end else begin
                span = idle_span();
                if (span > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (span) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // result checker: each accepted item against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t ns: result item 0x%h with no tick pending", $time, m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("level_phase_one", want.level_phase_one, got.level_phase_one);
                compare_field("level_phase_two", want.level_phase_two, got.level_phase_two);
                compare_field("level_phase_three", want.level_phase_three,
                              got.level_phase_three);
                compare_field("kill_out", want.kill_out, got.kill_out);
                compare_field("charging_out", want.charging_out, got.charging_out);
                compare_field("auto_out", want.auto_out, got.auto_out);
                compare_field("drop_fire", want.drop_fire, got.drop_fire);
                compare_field("drop_length_ms", want.drop_length_ms, got.drop_length_ms);
                compare_field("drop_refused", want.drop_refused, got.drop_refused);
                compare_field("clamp_trip", want.clamp_trip, got.clamp_trip);
                compare_field("stall_trip", want.stall_trip, got.stall_trip);
                compare_field("ready_light", want.ready_light, got.ready_light);
                compare_field("pad", want.pad, got.pad);
            end
        end
    end

    initial begin : stimulus
        t_row               rows [DIRECTED_ROWS];
        int                 k, s, pick, offs;
        longint             vq8;
        logic [CMD_W-1:0]   cmd;
        logic [COUNT_W-1:0] cnt;

        // local model out of reset
        cfg_target  = TARGET_RST;
        cfg_limit   = LIMIT_RST;
        cfg_scale   = SCALE_RST;
        cfg_phase   = PHASE_RST;
        cfg_pulse   = PULSE_RST;
        duty_q20    = '0;
        charging    = 1'b0;
        auto_mode   = 1'b0;
        killed      = 1'b1;
        stall_ticks = '0;

        // directed rows under the reset registers (target 60 V, pulse 3 ms)
        rows = '{
            // idle after reset: only the kill flag
            '{CMD_NONE,      12'd0,    1'b1, flag_result(1, 0, 0, 0, 0, 0)},
            // drop on an empty bus is refused
            '{CMD_DROP,      12'd0,    1'b1, flag_result(1, 0, 1, 0, 0, 0)},
            // full-scale count trips the clamp, ready light on
            '{CMD_NONE,      12'd4095, 1'b1, flag_result(1, 0, 0, 1, 1, 0)},
            // drop still fires in a clamp tick
            '{CMD_DROP,      12'd4095, 1'b1, flag_result(1, 0, 0, 1, 1, 3)},
            // charge from zero: first raise is too small to show in the level
            '{CMD_CHARGE,    12'd0,    1'b1, flag_result(0, 1, 0, 0, 0, 0)},
            '{CMD_NONE,      12'd0,    1'b0, '0},
            '{CMD_AUTO,      12'd0,    1'b0, '0},
            '{CMD_AUTO,      12'd0,    1'b0, '0},
            // auto on at the target: auto fire and ready
            '{CMD_AUTO,      12'd1816, 1'b0, '0},
            // single drop and auto fire together give one pulse
            '{CMD_DROP,      12'd1816, 1'b0, '0},
            // just above the clamp level
            '{CMD_NONE,      12'd2200, 1'b0, '0},
            // charge with the bus over target: cut below zero
            '{CMD_CHARGE,    12'd2100, 1'b0, '0},
            '{CMD_BOOST_OFF, 12'd100,  1'b0, '0},
            '{CMD_SPARE_LO,  12'd0,    1'b0, '0},
            '{CMD_SPARE_HI,  12'd1000, 1'b0, '0},
            '{CMD_KILL,      12'd1000, 1'b0, '0},
            // full raise, then partial raise, deadband and cut
            '{CMD_CHARGE,    12'd1500, 1'b0, '0},
            '{CMD_NONE,      12'd1700, 1'b0, '0},
            '{CMD_NONE,      12'd1816, 1'b0, '0},
            '{CMD_NONE,      12'd1900, 1'b0, '0},
            '{CMD_AUTO,      12'd2000, 1'b0, '0},
            // stop and kill clears everything
            '{CMD_KILL,      12'd0,    1'b1, flag_result(1, 0, 0, 0, 0, 0)},
            '{CMD_NONE,      12'd4095, 1'b1, flag_result(1, 0, 0, 1, 1, 0)}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        settings_used = 1;

        for (k = 0; k < DIRECTED_ROWS; k++)
            send_tick(rows[k].cmd, rows[k].cnt, rows[k].known, rows[k].want);
        drain_ticks();

        // short ramp, then a duty limit below the duty already reached
        load_settings(60, 576717, 2165, 7, 3);
        send_tick(CMD_CHARGE, 12'd0);
        for (k = 0; k < RAMP_TICKS; k++)
            send_tick(CMD_NONE, $urandom_range(0, 700));
        repeat (2) send_tick(CMD_NONE, 12'd1816);
        drain_ticks();
        apb_write(REG_LIMIT, 4000);
        // deadband keeps the old duty, the next raise clamps it
        repeat (2) send_tick(CMD_NONE, 12'd1816);
        send_tick(CMD_NONE, 12'd300);
        send_tick(CMD_NONE, 12'd1816);
        drain_ticks();

        // long ramp on a dead bus until the stall watchdog trips
        load_settings(90, 734003, 2165, 7, 20);
        send_tick(CMD_CHARGE, 12'd0);
        for (k = 0; k < STALL_RUN_TICKS; k++) begin
            case ($urandom_range(0, 19))
                0, 1:    cmd = CMD_DROP;
                2:       cmd = CMD_AUTO;
                3:       cmd = CMD_SPARE_LO;
                4:       cmd = CMD_SPARE_HI;
                default: cmd = CMD_NONE;
            endcase
            send_tick(cmd, $urandom_range(0, 700));
        end
        drain_ticks();

        // random charge sessions under extreme and random settings
        for (s = 0; s < RANDOM_SETS; s++) begin
            case (s)
                0: load_settings(30, 104858, 2165, 7, 1);
                1: load_settings(90, 734003, 65535, 0, 20);
                2: load_settings(45, 300000, 0, 5, 31);
                3: load_settings(127, 600000, 3000, 6, 0);
                4: load_settings(0, 20000, 1000, 3, 12);
                default: load_settings($urandom_range(30, 90), $urandom_range(104858, 734003),
                                       $urandom_range(1500, 4000), $urandom_range(0, 7),
                                       $urandom_range(1, 20));
            endcase
            for (k = 0; k < RANDOM_TICKS; k++) begin
                // session opens with a charge, then mostly plain ticks
                if (k == 0) cmd = CMD_CHARGE;
                else if ($urandom_range(0, 9) < 7) cmd = CMD_NONE;
                else cmd = $urandom_range(0, (1 << CMD_W) - 1);
                pick = $urandom_range(0, 9);
                if (pick < 2 || cfg_scale == 0) begin
                    cnt = $urandom_range(0, 4095);
                end else if (pick < 4) begin
                    cnt = $urandom_range(0, 200);
                end else begin
                    // bus within 14 V of target, across deadband, ready and clamp
                    offs = $urandom_range(0, 7168);
                    vq8  = cfg_target;
                    vq8  = vq8 * 256 + offs - 3584;
                    if (vq8 < 0) vq8 = 0;
                    vq8 = (vq8 << 8) / cfg_scale;
                    cnt = (vq8 > 4095) ? 12'd4095 : vq8[COUNT_W-1:0];
                end
                send_tick(cmd, cnt);
            end
            drain_ticks();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d ticks under %0d register settings", ticks_sent,
                 settings_used);
        $display("clamp trips %0d, stall trips %0d, drops fired %0d, drops refused %0d",
                 clamp_trips, stall_trips, drops_fired, drops_refused);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### boost_charge_supervisor_core.f
sv/bcs_pkg.sv
sv/bcs_regs.sv
sv/bcs_ctrl.sv
sv/bcs_dp.sv
sv/boost_charge_supervisor_core.sv
test/testbench.sv
